### design/nicrx_pkg.sv
// ----------------------------------------------------------------------------
// nicrx_pkg
// Shared types and constants for the receive ring deframer: result kinds,
// the result payload and the internal result transaction.
// ----------------------------------------------------------------------------
package nicrx_pkg;

   // Ring header layout and frame limits
   localparam int HDR_BYTES    = 4;
   localparam int MIN_GOOD_LEN = 18;
   localparam int RP_BACKOFF   = 16;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_FRAME_DONE = 2'd1,
      KIND_RING_RESET = 2'd2
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic        delivered;
      logic [15:0] read_pointer;
   } rsp_payload_type;

   // Result transaction from the parser to the result register
   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } result_type;

endpackage

### design/nicrx_if.sv
// ----------------------------------------------------------------------------
// nicrx_if
// Valid/ready channels of the receive ring deframer: ring bytes in,
// result items out.
// ----------------------------------------------------------------------------

// Ring byte channel
interface nicrx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ring_byte;

   modport source (output valid, output ring_byte, input ready);
   modport sink   (input valid, input ring_byte, output ready);
endinterface

// Result channel
interface nicrx_rsp_if import nicrx_pkg::*; ;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  payload_byte;
   logic        payload_last;
   logic        delivered;
   logic [15:0] read_pointer;

   modport source (output valid, output kind, output payload_byte, output payload_last,
                   output delivered, output read_pointer, input ready);
   modport sink   (input valid, input kind, input payload_byte, input payload_last,
                   input delivered, input read_pointer, output ready);
endinterface

### design/nicrx_in_stage.sv
// ----------------------------------------------------------------------------
// nicrx_in_stage
// Input register for ring bytes. Takes a new transaction whenever the
// register is empty or the parser consumes the byte it holds.
// ----------------------------------------------------------------------------
module nicrx_in_stage (
   input  logic        clock,
   input  logic        reset,
   nicrx_req_if.sink   req_ch,
   input  logic        take,
   output logic        item_valid,
   output logic [7:0]  item_byte
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       load;

   // Accept while empty or while the held byte drains this cycle
   assign req_ch.ready = !valid_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   // Hold or refill the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_ch.ring_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

### design/nicrx_parse.sv
// ----------------------------------------------------------------------------
// nicrx_parse
// Header and body tracking for the receive ring. Collects the 4-byte
// header, checks the length, then walks the frame body, producing
// payload bytes, a frame-done result at the aligned end, or a ring reset.
// ----------------------------------------------------------------------------
module nicrx_parse import nicrx_pkg::*; #(
   parameter int RING_BYTES = 8208,
   parameter int MAX_FRAME  = 1514
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        rx_enable,
   input  logic        item_valid,
   input  logic [7:0]  item_byte,
   input  logic        take,
   output result_type  result
);

   // Offset holds values below RING_BYTES (assumes MAX_FRAME + 11 <= RING_BYTES)
   localparam int MAX_LEN = MAX_FRAME + HDR_BYTES;
   localparam int OFF_W   = $clog2(RING_BYTES);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int TOT_W   = $clog2(MAX_LEN + 8);
   localparam int END_W   = $clog2(RING_BYTES + MAX_LEN + 8);
   localparam int RPX_W   = (OFF_W > 16) ? OFF_W : 16;

   // Header byte positions
   localparam logic [1:0] HDR_STATUS_LO = 2'd0;
   localparam logic [1:0] HDR_STATUS_HI = 2'd1;
   localparam logic [1:0] HDR_LEN_LO    = 2'd2;
   localparam logic [1:0] HDR_LEN_HI    = 2'd3;
   localparam int         STATUS_OK_BIT = 0;

   typedef enum logic {
      PH_HEADER,
      PH_BODY
   } phase_type;

   phase_type        phase_ff,   phase_in;
   logic [1:0]       hdr_cnt_ff, hdr_cnt_in;
   logic             status_ok_ff, status_ok_in;
   logic [7:0]       len_lo_ff,  len_lo_in;
   logic [LEN_W-1:0] len_ff,     len_in;
   logic             good_ff,    good_in;
   logic [TOT_W-1:0] total_ff,   total_in;
   logic [END_W-1:0] end_ff,     end_in;
   logic [TOT_W-1:0] idx_ff,     idx_in;
   logic [OFF_W-1:0] offset_ff,  offset_in;
   result_type       result_in;

   logic             fire;
   logic [15:0]      hdr_len;
   logic             hdr_bad;
   logic [END_W-1:0] end_sum;
   logic [END_W-1:0] end_aligned;
   logic [TOT_W-1:0] idx_next;
   logic [OFF_W-1:0] wrap_off;
   logic [RPX_W-1:0] rp_full;

   assign fire = item_valid && take;

   // Header length check and aligned frame end
   assign hdr_len     = {item_byte, len_lo_ff};
   assign hdr_bad     = (int'(hdr_len) < HDR_BYTES) || (int'(hdr_len) > MAX_LEN);
   assign end_sum     = END_W'(offset_ff) + END_W'(hdr_len) + END_W'(HDR_BYTES + 3);
   assign end_aligned = end_sum & ~END_W'(3);

   // Body position and wrapped next-frame offset
   assign idx_next = idx_ff + TOT_W'(1);
   assign wrap_off = (end_ff >= END_W'(RING_BYTES)) ?
                     OFF_W'(end_ff - END_W'(RING_BYTES)) : OFF_W'(end_ff);
   assign rp_full  = RPX_W'(wrap_off) - RPX_W'(RP_BACKOFF);

   // Next state and result
   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      status_ok_in = status_ok_ff;
      len_lo_in    = len_lo_ff;
      len_in       = len_ff;
      good_in      = good_ff;
      total_in     = total_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      offset_in    = offset_ff;
      result_in    = '0;

      if (fire && rx_enable) begin
         unique case (phase_ff)
            PH_HEADER: begin
               unique case (hdr_cnt_ff)
                  HDR_STATUS_LO: begin
                     status_ok_in = item_byte[STATUS_OK_BIT];
                     hdr_cnt_in   = hdr_cnt_ff + 2'd1;
                  end
                  HDR_STATUS_HI: begin
                     hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  end
                  HDR_LEN_LO: begin
                     len_lo_in  = item_byte;
                     hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  end
                  HDR_LEN_HI: begin
                     hdr_cnt_in = HDR_STATUS_LO;
                     if (hdr_bad) begin
                        // Corrupt header: restart at the ring base
                        offset_in                   = '0;
                        result_in.valid             = 1'b1;
                        result_in.data.kind         = KIND_RING_RESET;
                        result_in.data.read_pointer = 16'(-RP_BACKOFF);
                     end else begin
                        phase_in = PH_BODY;
                        len_in   = LEN_W'(hdr_len);
                        good_in  = status_ok_ff && (int'(hdr_len) >= MIN_GOOD_LEN);
                        end_in   = end_aligned;
                        total_in = TOT_W'(end_aligned - END_W'(offset_ff));
                        idx_in   = TOT_W'(HDR_BYTES);
                     end
                  end
                  default: begin
                     hdr_cnt_in = HDR_STATUS_LO;
                  end
               endcase
            end
            PH_BODY: begin
               if (good_ff && (idx_ff < TOT_W'(len_ff))) begin
                  // Pass a payload byte, mark the one before the CRC
                  idx_in                      = idx_next;
                  result_in.valid             = 1'b1;
                  result_in.data.kind         = KIND_PAYLOAD;
                  result_in.data.payload_byte = item_byte;
                  result_in.data.payload_last = (idx_next == TOT_W'(len_ff));
               end else if (idx_next >= total_ff) begin
                  // Last byte before the aligned end: advance the offset
                  offset_in                   = wrap_off;
                  phase_in                    = PH_HEADER;
                  hdr_cnt_in                  = HDR_STATUS_LO;
                  idx_in                      = '0;
                  result_in.valid             = 1'b1;
                  result_in.data.kind         = KIND_FRAME_DONE;
                  result_in.data.delivered    = good_ff;
                  result_in.data.read_pointer = rp_full[15:0];
               end else begin
                  // Drop CRC, padding or skipped frame bytes
                  idx_in = idx_next;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= HDR_STATUS_LO;
         status_ok_ff <= 1'b0;
         len_lo_ff    <= '0;
         len_ff       <= '0;
         good_ff      <= 1'b0;
         total_ff     <= '0;
         end_ff       <= '0;
         idx_ff       <= '0;
         offset_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         status_ok_ff <= status_ok_in;
         len_lo_ff    <= len_lo_in;
         len_ff       <= len_in;
         good_ff      <= good_in;
         total_ff     <= total_in;
         end_ff       <= end_in;
         idx_ff       <= idx_in;
         offset_ff    <= offset_in;
      end
   end

   // Result goes straight to the result register, which loads it this cycle
   assign result = result_in;

endmodule

### design/nicrx_out_stage.sv
// ----------------------------------------------------------------------------
// nicrx_out_stage
// Result register. Loads a result transaction whenever it is empty or the
// held result is taken, and drives the result channel.
// ----------------------------------------------------------------------------
module nicrx_out_stage import nicrx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  result_type  result,
   output logic        take,
   nicrx_rsp_if.source rsp_ch
);

   logic            valid_ff;
   rsp_payload_type data_ff;

   // Free to load when empty or draining
   assign take = !valid_ff || rsp_ch.ready;

   // Hold or refill the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = data_ff.kind;
   assign rsp_ch.payload_byte = data_ff.payload_byte;
   assign rsp_ch.payload_last = data_ff.payload_last;
   assign rsp_ch.delivered    = data_ff.delivered;
   assign rsp_ch.read_pointer = data_ff.read_pointer;

endmodule

### design/nic_rx_ring_deframer_core.sv
// ----------------------------------------------------------------------------
// nic_rx_ring_deframer_core
// Path: an accepted ring byte is held in the input register, then its result in the
//   result register. The header/body update between them is combinational.
// Throughput: one ring byte per cycle while the result register is free to load.
// Reset: clears the parser to header collection at ring offset 0, empties both
//   registers and clears rx_enable.
// ----------------------------------------------------------------------------
module nic_rx_ring_deframer_core import nicrx_pkg::*; #(
   parameter int RING_BYTES = 8208,
   parameter int MAX_FRAME  = 1514
) (
   input  logic        clock,
   input  logic        reset,
   nicrx_req_if.sink   req_ch,
   nicrx_rsp_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic       rx_enable_ff;
   logic       take;
   logic       item_valid;
   logic [7:0] item_byte;
   result_type result;

   // Hold the enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         rx_enable_ff <= csr_wr_data;
      end
   end

   nicrx_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   nicrx_parse #(
      .RING_BYTES (RING_BYTES),
      .MAX_FRAME  (MAX_FRAME)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .rx_enable  (rx_enable_ff),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .take       (take),
      .result     (result)
   );

   nicrx_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .result (result),
      .take   (take),
      .rsp_ch (rsp_ch)
   );

   // No result right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   // A freshly loaded result needs a held byte and an enabled block
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !($past(rsp_ch.valid) && !$past(rsp_ch.ready)))
      |-> ($past(item_valid) && $past(rx_enable_ff)))
      else $error("result loaded without a ring byte");

   // A ring reset always reports the rewound read pointer
   a_ring_reset_pointer: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == KIND_RING_RESET))
      |-> (rsp_ch.read_pointer == 16'(-RP_BACKOFF)))
      else $error("ring reset with wrong read pointer");

endmodule
